### rtl/cmwc_pkg.sv
// Package for the complementary multiply-with-carry generator.
// Holds widths, constants, the function codes and the control structs.
// No dependencies; every other file imports it.
`default_nettype none

package cmwc_pkg;

    // Lag table geometry.
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Datapath widths.
    localparam int WORD_W  = 32;
    localparam int MULT_W  = 15;
    localparam int PROD_W  = WORD_W + MULT_W;
    localparam int CARRY_W = 19;

    // Generator constants.
    localparam logic [CARRY_W-1:0] CARRY_INIT = CARRY_W'(362436);
    localparam logic [WORD_W-1:0]  PHI_WORD   = 32'h9e37_79b9;
    localparam logic [MULT_W-1:0]  MULT       = MULT_W'(18705);
    localparam logic [WORD_W-1:0]  COMPL_BASE = 32'hffff_fffe;
    localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(TABLE_DEPTH - 1);

    // Request codes carried in the func field.
    typedef enum logic {
        FUNC_SEED = 1'b0,
        FUNC_NEXT = 1'b1
    } t_func;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_next;  // advance index, read the table entry
        logic fill_start;  // capture the seed, restart the fill counter
        logic fill_step;   // write one table entry of the seed fill
        logic mul;         // register the product
        logic wb;          // write back the new word, update carry and output
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;   // the fill counter points at the last entry
        logic out_busy;    // the output register holds a word not yet taken
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/cmwc_if.sv
// Handshake channels of the generator: the request channel and the result channel.
// Depends on cmwc_pkg for the field widths.
`default_nettype none

interface cmwc_in_if
    import cmwc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [WORD_W-1:0] seed_value;

    modport source (output valid, output func, output seed_value, input ready);
    modport sink   (input valid, input func, input seed_value, output ready);
endinterface

interface cmwc_out_if
    import cmwc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

### rtl/cmwc_datapath.sv
// Datapath of the generator: lag table memory, index, carry, fill history,
// multiplier and output register. Driven by cmwc_ctrl; depends on cmwc_pkg.
`default_nettype none

module cmwc_datapath
    import cmwc_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  wire   [WORD_W-1:0] i_seed_value,
    input  wire                i_out_ready,
    output t_dp_sts            o_sts,
    output logic               o_out_valid,
    output logic  [WORD_W-1:0] o_out_data
);

    // Lag table, one write and one read port.
    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    logic [IDX_W-1:0]   r_index;
    logic [IDX_W-1:0]   n_index;
    logic [CARRY_W-1:0] r_carry;
    logic [CARRY_W-1:0] n_carry;
    logic [WORD_W-1:0]  r_rd_data;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  t_sum;
    logic [WORD_W-1:0]  n_word;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_data;

    // Seed fill state: counter, seed and the three most recent entries.
    logic [IDX_W-1:0]   r_k;
    logic [WORD_W-1:0]  r_seed;
    logic [WORD_W-1:0]  r_w1;
    logic [WORD_W-1:0]  r_w2;
    logic [WORD_W-1:0]  r_w3;
    logic [WORD_W-1:0]  n_fill_word;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;

    // Wrapping index advance.
    assign n_index = (r_index == IDX_LAST) ? '0 : r_index + 1'b1;

    // Carry add after the registered product, then the complement.
    assign t_sum   = r_prod + PROD_W'(r_carry);
    assign n_word  = COMPL_BASE - t_sum[WORD_W-1:0];
    assign n_carry = CARRY_W'(t_sum[PROD_W-1:WORD_W]);

    // Fill value: seed, two steps of PHI, then the XOR recurrence.
    always_comb begin
        if (r_k == '0) begin
            n_fill_word = r_seed;
        end else if (r_k < IDX_W'(3)) begin
            n_fill_word = r_w1 + PHI_WORD;
        end else begin
            n_fill_word = r_w3 ^ r_w2 ^ PHI_WORD ^ WORD_W'(r_k);
        end
    end

    // Memory write port is shared by the fill and the write-back.
    always_comb begin
        wr_en   = i_cmd.fill_step | i_cmd.wb;
        wr_addr = i_cmd.fill_step ? r_k : r_index;
        wr_data = i_cmd.fill_step ? n_fill_word : n_word;
    end

    // Table memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.start_next) begin
            r_rd_data <= mem[n_index];
        end
    end

    // Index, carry and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= IDX_LAST;
            r_carry     <= CARRY_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start_next) begin
                r_index <= n_index;
            end
            if (i_cmd.wb) begin
                r_carry     <= n_carry;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: product, output word and fill history.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(MULT) * PROD_W'(r_rd_data);
        end
        if (i_cmd.wb) begin
            r_out_data <= n_word;
        end
        if (i_cmd.fill_start) begin
            r_seed <= i_seed_value;
            r_k    <= '0;
        end else if (i_cmd.fill_step) begin
            r_k  <= r_k + 1'b1;
            r_w1 <= n_fill_word;
            r_w2 <= r_w1;
            r_w3 <= r_w2;
        end
    end

    assign o_sts.fill_last = (r_k == IDX_LAST);
    assign o_sts.out_busy  = r_out_valid & ~i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

endmodule

`default_nettype wire

### rtl/cmwc_ctrl.sv
// Controller of the generator: sequences seed fills and next requests.
// Issues commands to cmwc_datapath; depends on cmwc_pkg.
`default_nettype none

module cmwc_ctrl
    import cmwc_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    input  wire      i_in_func,
    input  t_dp_sts  i_sts,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_MUL,
        S_WB
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   accept;

    assign accept = r_in_ready & i_in_valid;

    // Commands decoded from the state and the request transfer.
    always_comb begin
        o_cmd.start_next = accept & (t_func'(i_in_func) == FUNC_NEXT);
        o_cmd.fill_start = accept & (t_func'(i_in_func) == FUNC_SEED);
        o_cmd.fill_step  = (r_state == S_FILL);
        o_cmd.mul        = (r_state == S_MUL);
        o_cmd.wb         = (r_state == S_WB) & ~i_sts.out_busy;
    end

    // State and request ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_in_ready <= 1'b0;
                        if (t_func'(i_in_func) == FUNC_NEXT) begin
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_FILL;
                        end
                    end
                end
                S_FILL: begin
                    if (i_sts.fill_last) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                S_MUL: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (!i_sts.out_busy) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready = r_in_ready;

    // Ready is only offered while no request is in progress.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_ready |-> (r_state == S_IDLE))
        else $error("request ready outside the idle state");

    // A transfer closes the request channel on the next cycle.
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_in_ready)
        else $error("request channel still open after a transfer");

    // A fill runs without a break until the last entry is written.
    a_fill_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && !i_sts.fill_last) |=> (r_state == S_FILL))
        else $error("seed fill left before the last entry");

    // A write-back only happens while the output register can take the word.
    a_wb_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wb |-> !i_sts.out_busy)
        else $error("write-back with a pending output word");

    // A finished write-back reopens the request channel.
    a_wb_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wb |=> r_in_ready)
        else $error("request channel not reopened after write-back");

endmodule

`default_nettype wire

### rtl/cmwc_random_generator.sv
// Complementary multiply-with-carry random word generator with a lag table of
// TABLE_DEPTH 32-bit words held in one single-port-write memory. A seed request
// (func 0) rewrites the whole table, one entry per cycle through the memory
// write port, and gives no result. A next request (func 1) runs a registered
// table read, a registered 18705 x word product, then carry add, write-back
// and output register load; the next request is taken the cycle after. The
// output word sits in a register, so a request is taken while an earlier
// word waits; a write-back stalls only while the output register is still
// full. Seed the table before the first next request. Depends on cmwc_pkg,
// cmwc_if, cmwc_ctrl and cmwc_datapath.
`default_nettype none

module cmwc_random_generator
    import cmwc_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    cmwc_in_if.sink           i_in,
    cmwc_out_if.source        o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    // Sequencer.
    cmwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // Table, arithmetic and output register.
    cmwc_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_seed_value (i_in.seed_value),
        .i_out_ready  (o_out.ready),
        .o_sts        (sts),
        .o_out_valid  (o_out.valid),
        .o_out_data   (o_out.random_value)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for cmwc_random_generator: seed and next requests go in,
// and every random word that comes out is checked against a cycle-free model of the generator.
// Depends on cmwc_pkg, cmwc_if and the generator RTL.
`default_nettype none

module testbench;
    import cmwc_pkg::*;

    localparam int RANDOM_REQS = 1050;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT_WORD = 150;

    typedef struct packed {
        t_func             func;
        logic [WORD_W-1:0] seed_value;
    } gen_req_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cmwc_in_if  req_bus ();
    cmwc_out_if word_bus ();

    cmwc_random_generator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus),
        .o_out   (word_bus)
    );

    // Free-running clock with a 12-unit period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Model state: lag table, table index and carry.
    logic [WORD_W-1:0]  lag_words [TABLE_DEPTH];
    logic [IDX_W-1:0]   word_idx;
    logic [CARRY_W-1:0] mwc_carry;

    gen_req_t          pending_reqs[$];
    logic [WORD_W-1:0] expected_words[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    // A seed rewrites the whole table from the seed, its golden-ratio offsets and an XOR recurrence.
    function automatic void fill_lag_table(input logic [WORD_W-1:0] s);
        lag_words[0] = s;
        lag_words[1] = s + PHI_WORD;
        lag_words[2] = s + PHI_WORD + PHI_WORD;
        for (int k = 3; k < TABLE_DEPTH; k++)
            lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ PHI_WORD ^ WORD_W'(k);
    endfunction

    // One multiply-with-carry step: advance the index, fold in the carry,
    // and store the complemented low word back into the table.
    function automatic logic [WORD_W-1:0] next_random_word();
        logic [63:0]       t;
        logic [WORD_W-1:0] w;
        word_idx = (word_idx == IDX_LAST) ? '0 : word_idx + 1'b1;
        t = 64'(MULT) * 64'(lag_words[word_idx]) + 64'(mwc_carry);
        mwc_carry = CARRY_W'(t >> WORD_W);
        w = COMPL_BASE - t[WORD_W-1:0];
        lag_words[word_idx] = w;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] pick_seed();
        logic [WORD_W-1:0] s;
        case ($urandom_range(7))
            0: s = '0;
            1: s = '1;
            2: s = 32'h8000_0000;
            3: s = -PHI_WORD;
            default: s = $urandom;
        endcase
        return s;
    endfunction

    // Request driver: presents queued requests, idling at random outside the calm
    // stretch and the result hold-off, and never while the receiver holds off.
    always @(posedge i_clk) begin
        static int unsigned items_sent = 0;
        gen_req_t req;
        if (!i_rst_n) begin
            req_bus.valid      <= 1'b0;
            req_bus.func       <= FUNC_SEED;
            req_bus.seed_value <= '0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                items_sent++;
                if (req_bus.func == FUNC_SEED)
                    fill_lag_table(req_bus.seed_value);
                else
                    expected_words.push_back(next_random_word());
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_reqs.size() != 0 &&
                    ((items_sent >= 500 && items_sent < 700) || hold_left != 0 ||
                     $urandom_range(99) >= 34)) begin
                    req = pending_reqs.pop_front();
                    req_bus.valid      <= 1'b1;
                    req_bus.func       <= req.func;
                    req_bus.seed_value <= req.seed_value;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each word transfer and drives ready, with one long hold-off.
    always @(posedge i_clk) begin
        static int unsigned words_seen = 0;
        logic [WORD_W-1:0] want;
        if (!i_rst_n) begin
            word_bus.ready <= 1'b0;
        end else begin
            if (word_bus.valid && word_bus.ready) begin
                words_seen++;
                if (expected_words.size() == 0) begin
                    $error("random_value %h arrived with nothing expected",
                           word_bus.random_value);
                    mismatch_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (word_bus.random_value !== want) begin
                        $error("random_value mismatch: expected %h, got %h",
                               want, word_bus.random_value);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left      <= hold_left - 1;
                word_bus.ready <= 1'b0;
            end else if (words_seen == HOLD_AT_WORD && !hold_done) begin
                hold_left      <= HOLD_CYCLES;
                hold_done      <= 1'b1;
                word_bus.ready <= 1'b0;
            end else begin
                word_bus.ready <= (words_seen >= 400 && words_seen < 600) ||
                                  $urandom_range(99) >= 34;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        req_bus.valid      = 1'b0;
        req_bus.func       = FUNC_SEED;
        req_bus.seed_value = '0;
        word_bus.ready     = 1'b0;
        word_idx  = IDX_LAST;
        mwc_carry = CARRY_INIT;

        // Directed requests: extreme seeds, back-to-back seeds, seeds whose offsets
        // wrap, and next requests carrying junk in the ignored seed field.
        pending_reqs.push_back('{FUNC_SEED, 32'h0000_0000});
        pending_reqs.push_back('{FUNC_NEXT, 32'hffff_ffff});
        pending_reqs.push_back('{FUNC_NEXT, 32'h0000_0000});
        pending_reqs.push_back('{FUNC_NEXT, 32'h5555_aaaa});
        pending_reqs.push_back('{FUNC_SEED, 32'hffff_ffff});
        pending_reqs.push_back('{FUNC_SEED, 32'h0000_0001});
        pending_reqs.push_back('{FUNC_NEXT, 32'haaaa_5555});
        pending_reqs.push_back('{FUNC_NEXT, 32'h0000_0000});
        pending_reqs.push_back('{FUNC_SEED, -PHI_WORD});
        pending_reqs.push_back('{FUNC_NEXT, 32'hffff_ffff});
        pending_reqs.push_back('{FUNC_SEED, PHI_WORD});
        pending_reqs.push_back('{FUNC_NEXT, 32'h0000_0000});
        pending_reqs.push_back('{FUNC_SEED, 32'h8000_0000});
        pending_reqs.push_back('{FUNC_NEXT, 32'h7fff_ffff});
        pending_reqs.push_back('{FUNC_NEXT, 32'h8000_0000});
        pending_reqs.push_back('{FUNC_NEXT, 32'h0000_0001});
        pending_reqs.push_back('{FUNC_SEED, 32'h1234_5678});
        pending_reqs.push_back('{FUNC_SEED, 32'h7fff_ffff});
        pending_reqs.push_back('{FUNC_NEXT, 32'hffff_ffff});
        pending_reqs.push_back('{FUNC_NEXT, 32'hffff_ffff});

        // Random part: mostly next requests, with an occasional reseed.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if ($urandom_range(99) < 2)
                pending_reqs.push_back('{FUNC_SEED, pick_seed()});
            else
                pending_reqs.push_back('{FUNC_NEXT, WORD_W'($urandom)});
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all requests taken and every expected word delivered,
        // then let any seed fill still in progress run out.
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_bus.valid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (TABLE_DEPTH + 16) @(posedge i_clk);

        if (expected_words.size() != 0)
            $error("%0d random words never arrived", expected_words.size());
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/cmwc_pkg.sv
rtl/cmwc_if.sv
rtl/cmwc_datapath.sv
rtl/cmwc_ctrl.sv
rtl/cmwc_random_generator.sv
tb/testbench.sv
